// File: hw/rtl/rv32i_integer_execute_core_unit_macros.svh
// Assertion macros used by the checker file of the execute core.
`ifndef RV32I_INTEGER_EXECUTE_CORE_UNIT_MACROS_SVH
`define RV32I_INTEGER_EXECUTE_CORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RVXC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RVXC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rvxc_pkg.sv
// Shared types and opcode constants of the RV32I execute core.
package rvxc_pkg;

	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_ALUI   = 7'b0010011;
	localparam logic [6:0] OP_ALUR   = 7'b0110011;

	localparam logic [6:0] F7_ZERO = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// ALU funct3
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch funct3
	localparam logic [2:0] BR_EQ   = 3'd0;
	localparam logic [2:0] BR_NE   = 3'd1;
	localparam logic [2:0] BR_RSV0 = 3'd2;
	localparam logic [2:0] BR_RSV1 = 3'd3;
	localparam logic [2:0] BR_LT   = 3'd4;
	localparam logic [2:0] BR_GE   = 3'd5;
	localparam logic [2:0] BR_LTU  = 3'd6;
	localparam logic [2:0] BR_GEU  = 3'd7;

	localparam logic [2:0] JALR_F3 = 3'd0;

	localparam logic [31:0] U_MASK = 32'hFFFF_F000;

	// decoded-instruction queue
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		CLS_LUI,
		CLS_AUIPC,
		CLS_JAL,
		CLS_JALR,
		CLS_BRANCH,
		CLS_ALU,
		CLS_NOP
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [2:0]  funct3;
		logic        alt;
		logic        use_imm;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic        rd_ok;
		logic        rs1_ok;
		logic        rs2_ok;
		logic [31:0] imm;
	} dec_t;

endpackage

// File: hw/rtl/rvxc_front.sv
// Front end: decodes and classifies one instruction word.
module rvxc_front #(
	parameter int NUM_REGS = 32
) (
	input  logic [31:0]     instr_word,
	output rvxc_pkg::dec_t  dec
);

	logic [6:0]  op;
	logic [6:0]  f7;
	logic [2:0]  f3;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [31:0] imm_i;
	logic [31:0] imm_u;
	logic [31:0] imm_j;
	logic [31:0] imm_b;

	assign op    = instr_word[6:0];
	assign rd    = instr_word[11:7];
	assign f3    = instr_word[14:12];
	assign rs1   = instr_word[19:15];
	assign rs2   = instr_word[24:20];
	assign f7    = instr_word[31:25];
	assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
	assign imm_u = instr_word & rvxc_pkg::U_MASK;
	assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
		instr_word[20], instr_word[30:21], 1'b0};
	assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
		instr_word[30:25], instr_word[11:8], 1'b0};

	always_comb begin
		dec         = '0;
		dec.cls     = rvxc_pkg::CLS_NOP;
		dec.funct3  = f3;
		dec.rd      = rd;
		dec.rs1     = rs1;
		dec.rs2     = rs2;
		dec.rd_ok   = (rd != 5'd0) && (32'(rd) < 32'(NUM_REGS));
		dec.rs1_ok  = (rs1 != 5'd0) && (32'(rs1) < 32'(NUM_REGS));
		dec.rs2_ok  = (rs2 != 5'd0) && (32'(rs2) < 32'(NUM_REGS));
		dec.imm     = imm_i;
		unique case (op)
			rvxc_pkg::OP_LUI: begin
				dec.cls = rvxc_pkg::CLS_LUI;
				dec.imm = imm_u;
			end
			rvxc_pkg::OP_AUIPC: begin
				dec.cls = rvxc_pkg::CLS_AUIPC;
				dec.imm = imm_u;
			end
			rvxc_pkg::OP_JAL: begin
				dec.cls = rvxc_pkg::CLS_JAL;
				dec.imm = imm_j;
			end
			rvxc_pkg::OP_JALR: begin
				if (f3 == rvxc_pkg::JALR_F3) begin
					dec.cls = rvxc_pkg::CLS_JALR;
				end
			end
			rvxc_pkg::OP_BRANCH: begin
				dec.imm = imm_b;
				if (!(f3 inside {rvxc_pkg::BR_RSV0, rvxc_pkg::BR_RSV1})) begin
					dec.cls = rvxc_pkg::CLS_BRANCH;
				end
			end
			rvxc_pkg::OP_ALUI: begin
				dec.use_imm = 1'b1;
				if (f3 == rvxc_pkg::F3_SLL) begin
					if (f7 == rvxc_pkg::F7_ZERO) begin
						dec.cls = rvxc_pkg::CLS_ALU;
					end
				end else if (f3 == rvxc_pkg::F3_SR) begin
					if (f7 == rvxc_pkg::F7_ZERO || f7 == rvxc_pkg::F7_ALT) begin
						dec.cls = rvxc_pkg::CLS_ALU;
						dec.alt = (f7 == rvxc_pkg::F7_ALT);
					end
				end else begin
					dec.cls = rvxc_pkg::CLS_ALU;
				end
			end
			rvxc_pkg::OP_ALUR: begin
				if (f7 == rvxc_pkg::F7_ZERO) begin
					dec.cls = rvxc_pkg::CLS_ALU;
				end else if (f7 == rvxc_pkg::F7_ALT &&
						(f3 inside {rvxc_pkg::F3_ADD, rvxc_pkg::F3_SR})) begin
					dec.cls = rvxc_pkg::CLS_ALU;
					dec.alt = 1'b1;
				end
			end
			default: begin
				dec.cls = rvxc_pkg::CLS_NOP;
			end
		endcase
	end

endmodule

// File: hw/rtl/rvxc_fifo.sv
// Short queue of decoded instructions between front end and back end.
module rvxc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rvxc_pkg::dec_t din,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output rvxc_pkg::dec_t dout
);

	localparam int PTR_W = $clog2(rvxc_pkg::QDEPTH);
	localparam int CNT_W = $clog2(rvxc_pkg::QDEPTH + 1);

	rvxc_pkg::dec_t   slot_q [rvxc_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(rvxc_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: hw/rtl/rvxc_back.sv
// Back end: register read stage, execute stage, register file, PC, result register.
module rvxc_back #(
	parameter int NUM_REGS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  rvxc_pkg::dec_t q_data,
	output logic           q_pop,
	output logic           result_valid,
	input  logic           result_ready,
	output logic [31:0]    next_pc,
	output logic           wb_enable,
	output logic [4:0]     wb_index,
	output logic [31:0]    wb_value,
	output logic           branch_taken,
	output logic           unsupported
);

	localparam int IDX_W = $clog2(NUM_REGS);

	// register file: reset handled by per-entry valid bits
	logic [31:0]         rf_mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [31:0]         pc_q;

	// read stage
	rvxc_pkg::dec_t dec_s1;
	logic           vld_s1;
	logic [31:0]    rdat_a_s1;
	logic [31:0]    rdat_b_s1;
	logic           a_zero_s1;
	logic           b_zero_s1;
	logic           a_fwd_s1;
	logic           b_fwd_s1;
	logic [31:0]    fwd_s1;

	// result register
	logic        res_vld_q;
	logic [31:0] next_pc_q;
	logic        wb_enable_q;
	logic [4:0]  wb_index_q;
	logic [31:0] wb_value_q;
	logic        taken_q;
	logic        unsup_q;

	logic             fire;
	logic             load;
	logic [IDX_W-1:0] rs1_idx;
	logic [IDX_W-1:0] rs2_idx;
	logic [IDX_W-1:0] rd_idx;
	logic [31:0]      op_a;
	logic [31:0]      op_b;
	logic [31:0]      alu_b;
	logic [4:0]       sh;
	logic [31:0]      alu_res;
	logic             br_cond;
	logic [31:0]      pc4;
	logic [31:0]      nxt;
	logic [31:0]      val;
	logic             wr_cls;
	logic             taken;
	logic             wr_en;

	assign fire    = vld_s1 && (!res_vld_q || result_ready);
	assign load    = q_valid && (!vld_s1 || fire);
	assign q_pop   = load;
	assign rs1_idx = q_data.rs1[IDX_W-1:0];
	assign rs2_idx = q_data.rs2[IDX_W-1:0];
	assign rd_idx  = dec_s1.rd[IDX_W-1:0];

	assign op_a  = a_fwd_s1 ? fwd_s1 : (a_zero_s1 ? 32'd0 : rdat_a_s1);
	assign op_b  = b_fwd_s1 ? fwd_s1 : (b_zero_s1 ? 32'd0 : rdat_b_s1);
	assign alu_b = dec_s1.use_imm ? dec_s1.imm : op_b;
	assign sh    = alu_b[4:0];
	assign pc4   = pc_q + 32'd4;

	always_comb begin
		unique case (dec_s1.funct3)
			rvxc_pkg::F3_ADD:  alu_res = dec_s1.alt ? (op_a - alu_b) : (op_a + alu_b);
			rvxc_pkg::F3_SLL:  alu_res = op_a << sh;
			rvxc_pkg::F3_SLT:  alu_res = {31'd0, $signed(op_a) < $signed(alu_b)};
			rvxc_pkg::F3_SLTU: alu_res = {31'd0, op_a < alu_b};
			rvxc_pkg::F3_XOR:  alu_res = op_a ^ alu_b;
			rvxc_pkg::F3_SR:   alu_res = dec_s1.alt ? 32'($signed(op_a) >>> sh)
				: (op_a >> sh);
			rvxc_pkg::F3_OR:   alu_res = op_a | alu_b;
			rvxc_pkg::F3_AND:  alu_res = op_a & alu_b;
			default:           alu_res = '0;
		endcase
	end

	always_comb begin
		unique case (dec_s1.funct3)
			rvxc_pkg::BR_EQ:  br_cond = (op_a == op_b);
			rvxc_pkg::BR_NE:  br_cond = (op_a != op_b);
			rvxc_pkg::BR_LT:  br_cond = $signed(op_a) < $signed(op_b);
			rvxc_pkg::BR_GE:  br_cond = !($signed(op_a) < $signed(op_b));
			rvxc_pkg::BR_LTU: br_cond = (op_a < op_b);
			rvxc_pkg::BR_GEU: br_cond = (op_a >= op_b);
			default:          br_cond = 1'b0;
		endcase
	end

	always_comb begin
		nxt    = pc4;
		val    = '0;
		wr_cls = 1'b0;
		taken  = 1'b0;
		unique case (dec_s1.cls)
			rvxc_pkg::CLS_LUI: begin
				val    = dec_s1.imm;
				wr_cls = 1'b1;
			end
			rvxc_pkg::CLS_AUIPC: begin
				val    = pc_q + dec_s1.imm;
				wr_cls = 1'b1;
			end
			rvxc_pkg::CLS_JAL: begin
				val    = pc4;
				nxt    = pc_q + dec_s1.imm;
				wr_cls = 1'b1;
				taken  = 1'b1;
			end
			rvxc_pkg::CLS_JALR: begin
				val    = pc4;
				nxt    = (op_a + dec_s1.imm) & ~32'd1;
				wr_cls = 1'b1;
				taken  = 1'b1;
			end
			rvxc_pkg::CLS_BRANCH: begin
				if (br_cond) begin
					taken = 1'b1;
					nxt   = pc_q + dec_s1.imm;
				end
			end
			rvxc_pkg::CLS_ALU: begin
				val    = alu_res;
				wr_cls = 1'b1;
			end
			default: begin
				nxt = pc4;
			end
		endcase
		wr_en = fire && wr_cls && dec_s1.rd_ok;
	end

	// register file write and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem_q[rd_idx] <= val;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rdat_a_s1 <= rf_mem_q[rs1_idx];
			rdat_b_s1 <= rf_mem_q[rs2_idx];
		end
	end

	// read-stage payload; bypass covers the write landing on the same edge
	always_ff @(posedge clk) begin
		if (load) begin
			dec_s1    <= q_data;
			a_zero_s1 <= !(q_data.rs1_ok && rf_vld_q[rs1_idx]);
			b_zero_s1 <= !(q_data.rs2_ok && rf_vld_q[rs2_idx]);
			a_fwd_s1  <= wr_en && q_data.rs1_ok && (q_data.rs1 == dec_s1.rd);
			b_fwd_s1  <= wr_en && q_data.rs2_ok && (q_data.rs2 == dec_s1.rd);
			fwd_s1    <= val;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			next_pc_q    <= nxt;
			wb_enable_q  <= wr_en;
			wb_index_q   <= (wr_cls && dec_s1.rd_ok) ? dec_s1.rd : 5'd0;
			wb_value_q   <= (wr_cls && dec_s1.rd_ok) ? val : 32'd0;
			taken_q      <= taken;
			unsup_q      <= (dec_s1.cls == rvxc_pkg::CLS_NOP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			pc_q      <= '0;
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				rf_vld_q[rd_idx] <= 1'b1;
			end
			if (fire) begin
				pc_q <= nxt;
			end
			if (load) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				res_vld_q <= 1'b1;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_vld_q;
	assign next_pc      = next_pc_q;
	assign wb_enable    = wb_enable_q;
	assign wb_index     = wb_index_q;
	assign wb_value     = wb_value_q;
	assign branch_taken = taken_q;
	assign unsupported  = unsup_q;

endmodule

// File: hw/rtl/rv32i_integer_execute_core_unit.sv
// RV32I integer execute core: decode front end, queue, execute back end.
//
// Feeds on one 32-bit RV32I instruction word per transaction and returns one
// result transaction per word: the next PC, the register write-back (enable,
// index, value), a taken flag for jumps and taken branches, and an
// unsupported flag for loads, stores, unknown opcodes and illegal encodings,
// which retire as no-ops with PC+4. The PC is a byte address, resets to zero
// and steps by 4; the NUM_REGS-entry register file reads zero at reset and
// for x0 or any index at or above NUM_REGS. Rate: one instruction per clock
// sustained, with a new word taken every cycle while results are taken every
// cycle. An accepted word is decoded into a 2-entry queue, then passes the
// register-read stage with registered data (a bypass supplies the value
// written on the same edge), then the execute stage that updates the PC and
// register file and loads the result register, which raises result valid.
// That execute stage, where the PC and the register file both turn over
// each cycle that a result is taken, sets the throughput. A stalled result
// holds its register while up to three more words wait, one in the read
// stage and two in the queue; instr_ready drops only when the queue is full.
module rv32i_integer_execute_core_unit #(
	parameter int NUM_REGS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_ready,
	input  logic [31:0] instr_word,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] next_pc,
	output logic        wb_enable,
	output logic [4:0]  wb_index,
	output logic [31:0] wb_value,
	output logic        branch_taken,
	output logic        unsupported
);

	rvxc_pkg::dec_t front_dec;
	rvxc_pkg::dec_t q_head;
	logic           q_full;
	logic           q_nempty;
	logic           q_pop;
	logic           push;

	assign instr_ready = !q_full;
	assign push        = instr_valid && instr_ready;

	rvxc_front #(
		.NUM_REGS(NUM_REGS)
	) u_front (
		.instr_word(instr_word),
		.dec       (front_dec)
	);

	rvxc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (front_dec),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_nempty),
		.dout     (q_head)
	);

	rvxc_back #(
		.NUM_REGS(NUM_REGS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_nempty),
		.q_data      (q_head),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.next_pc     (next_pc),
		.wb_enable   (wb_enable),
		.wb_index    (wb_index),
		.wb_value    (wb_value),
		.branch_taken(branch_taken),
		.unsupported (unsupported)
	);

endmodule

// File: hw/rtl/rvxc_checker.sv
// Port-level assertion checker for the execute core, bound to the top level.
`include "rv32i_integer_execute_core_unit_macros.svh"

module rvxc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] next_pc,
	input logic        wb_enable,
	input logic [4:0]  wb_index,
	input logic [31:0] wb_value,
	input logic        branch_taken,
	input logic        unsupported
);

	`RVXC_ASSERT_NXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(next_pc) && $stable(wb_value) && $stable(wb_index), "result changed while stalled")
	`RVXC_ASSERT_IMP(a_nop_quiet, result_valid && unsupported, !wb_enable && !branch_taken, "no-op wrote a register or redirected")
	`RVXC_ASSERT_IMP(a_wb_clean, result_valid && !wb_enable, wb_index == 5'd0 && wb_value == 32'd0, "idle write-back fields not zero")
	`RVXC_ASSERT_IMP(a_wb_no_x0, result_valid && wb_enable, wb_index != 5'd0, "write-back to x0")

endmodule

bind rv32i_integer_execute_core_unit rvxc_checker u_rvxc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.next_pc     (next_pc),
	.wb_enable   (wb_enable),
	.wb_index    (wb_index),
	.wb_value    (wb_value),
	.branch_taken(branch_taken),
	.unsupported (unsupported)
);

// File: tb/tb_top.sv
// Self-checking testbench for the RV32I execute core: instruction stream in, retire records out.
`timescale 1ns / 1ps

import rvxc_pkg::*;

// One retired instruction as the core reports it.
typedef struct packed {
	logic [31:0] next_pc;
	logic        wb_enable;
	logic [4:0]  wb_index;
	logic [31:0] wb_value;
	logic        branch_taken;
	logic        unsupported;
} retire_t;

// Architectural shadow of the core plus the queue of retire records still owed.
class retire_scoreboard #(int NREGS = 32);
	logic [31:0] gpr [32];
	logic [31:0] pc;
	retire_t     retire_q [$];
	int          retired;
	int          errors;

	function new();
		foreach (gpr[i]) gpr[i] = '0;
		pc      = '0;
		retired = 0;
		errors  = 0;
	endfunction

	function int pending();
		return retire_q.size();
	endfunction

	task report(string msg);
		$display("MISMATCH retire %0d: %s", retired, msg);
		errors++;
	endtask

	function logic [31:0] read_gpr(logic [4:0] idx);
		if (idx == 5'd0 || int'(idx) >= NREGS) return '0;
		return gpr[idx];
	endfunction

	function logic [31:0] alu_result(logic [2:0] f3, logic alt, logic [31:0] a, logic [31:0] b);
		logic [4:0] sh;
		sh = b[4:0];
		case (f3)
			F3_ADD:  return alt ? a - b : a + b;
			F3_SLL:  return a << sh;
			F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
			F3_SLTU: return {31'd0, a < b};
			F3_XOR:  return a ^ b;
			F3_SR: begin
				if (alt) return $signed(a) >>> sh;
				return a >> sh;
			end
			F3_OR:   return a | b;
			default: return a & b;
		endcase
	endfunction

	// Executes one word against the shadow state and returns what the core must report.
	function retire_t execute_instr(logic [31:0] w);
		logic [6:0]  opc;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm_i;
		logic [31:0] imm_b;
		logic [31:0] imm_j;
		logic [31:0] val;
		logic [31:0] nxt;
		logic        wr;
		logic        tk;
		logic        bad;
		logic        cond;
		logic        alt;
		retire_t     r;

		opc   = w[6:0];
		rd    = w[11:7];
		f3    = w[14:12];
		f7    = w[31:25];
		a     = read_gpr(w[19:15]);
		b     = read_gpr(w[24:20]);
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		nxt   = pc + 32'd4;
		val   = '0;
		wr    = 1'b0;
		tk    = 1'b0;
		bad   = 1'b0;
		cond  = 1'b0;
		alt   = 1'b0;

		case (opc)
			OP_LUI: begin
				val = w & U_MASK;
				wr  = 1'b1;
			end
			OP_AUIPC: begin
				val = pc + (w & U_MASK);
				wr  = 1'b1;
			end
			OP_JAL: begin
				val = pc + 32'd4;
				nxt = pc + imm_j;
				wr  = 1'b1;
				tk  = 1'b1;
			end
			OP_JALR: begin
				if (f3 != JALR_F3) begin
					bad = 1'b1;
				end else begin
					val = pc + 32'd4;
					nxt = (a + imm_i) & ~32'd1;
					wr  = 1'b1;
					tk  = 1'b1;
				end
			end
			OP_BRANCH: begin
				case (f3)
					BR_EQ:   cond = (a == b);
					BR_NE:   cond = (a != b);
					BR_LT:   cond = ($signed(a) < $signed(b));
					BR_GE:   cond = ($signed(a) >= $signed(b));
					BR_LTU:  cond = (a < b);
					BR_GEU:  cond = (a >= b);
					default: bad = 1'b1;
				endcase
				if (cond) begin
					tk  = 1'b1;
					nxt = pc + imm_b;
				end
			end
			OP_ALUI: begin
				// shift-immediates carry funct7 in the upper immediate bits
				if (f3 == F3_SLL && f7 != F7_ZERO) begin
					bad = 1'b1;
				end else if (f3 == F3_SR) begin
					if (f7 != F7_ZERO && f7 != F7_ALT) bad = 1'b1;
					alt = (f7 == F7_ALT);
				end
				if (!bad) begin
					val = alu_result(f3, alt, a, imm_i);
					wr  = 1'b1;
				end
			end
			OP_ALUR: begin
				if (f7 != F7_ZERO && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
					bad = 1'b1;
				end else begin
					val = alu_result(f3, f7 == F7_ALT, a, b);
					wr  = 1'b1;
				end
			end
			default: bad = 1'b1;
		endcase

		if (bad) begin
			wr  = 1'b0;
			tk  = 1'b0;
			nxt = pc + 32'd4;
			val = '0;
		end
		if (!wr || rd == 5'd0 || int'(rd) >= NREGS) begin
			wr  = 1'b0;
			val = '0;
			rd  = '0;
		end else begin
			gpr[rd] = val;
		end
		pc = nxt;

		r.next_pc      = nxt;
		r.wb_enable    = wr;
		r.wb_index     = rd;
		r.wb_value     = val;
		r.branch_taken = tk;
		r.unsupported  = bad;
		return r;
	endfunction

	function void note_instr(logic [31:0] w);
		retire_q.push_back(execute_instr(w));
	endfunction

	task check_result(retire_t got);
		retire_t want;
		if (retire_q.size() == 0) begin
			report($sformatf("result transaction with nothing outstanding, next_pc %h", got.next_pc));
		end else begin
			want = retire_q.pop_front();
			if (got.next_pc !== want.next_pc)
				report($sformatf("next_pc got %h want %h", got.next_pc, want.next_pc));
			if (got.wb_enable !== want.wb_enable)
				report($sformatf("wb_enable got %b want %b", got.wb_enable, want.wb_enable));
			if (got.wb_index !== want.wb_index)
				report($sformatf("wb_index got %0d want %0d", got.wb_index, want.wb_index));
			if (got.wb_value !== want.wb_value)
				report($sformatf("wb_value got %h want %h", got.wb_value, want.wb_value));
			if (got.branch_taken !== want.branch_taken)
				report($sformatf("branch_taken got %b want %b", got.branch_taken, want.branch_taken));
			if (got.unsupported !== want.unsupported)
				report($sformatf("unsupported got %b want %b", got.unsupported, want.unsupported));
		end
		retired++;
	endtask
endclass

module tb_top;

	localparam int NUM_REGS     = 32;
	localparam int LIMIT_CYCLES = 200000;

	// opcodes the core retires as no-ops; not part of the shared package
	localparam logic [6:0] OPC_LOAD  = 7'b0000011;
	localparam logic [6:0] OPC_STORE = 7'b0100011;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        instr_valid  = 1'b0;
	logic [31:0] instr_word   = '0;
	logic        result_ready = 1'b0;
	logic        instr_ready;
	logic        result_valid;
	logic [31:0] next_pc;
	logic        wb_enable;
	logic [4:0]  wb_index;
	logic [31:0] wb_value;
	logic        branch_taken;
	logic        unsupported;

	int  cycle_count = 0;
	bit  send_calm   = 1'b0;

	retire_scoreboard #(NUM_REGS) sb;

	rv32i_integer_execute_core_unit #(
		.NUM_REGS(NUM_REGS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_ready (instr_ready),
		.instr_word  (instr_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.next_pc     (next_pc),
		.wb_enable   (wb_enable),
		.wb_index    (wb_index),
		.wb_value    (wb_value),
		.branch_taken(branch_taken),
		.unsupported (unsupported)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Both handshakes are sampled here, before this edge's updates land.
	// The input transaction is noted first so the shadow state is never behind.
	always @(posedge clk) begin
		if (arst_n) begin
			if (instr_valid && instr_ready)
				sb.note_instr(instr_word);
			if (result_valid && result_ready)
				sb.check_result({next_pc, wb_enable, wb_index, wb_value, branch_taken, unsupported});
		end
	end

	// ---------------------------------------------------------------
	// Instruction encoders
	// ---------------------------------------------------------------
	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
		return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
	endfunction

	function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] opc);
		return {imm, rd, opc};
	endfunction

	// ---------------------------------------------------------------
	// Random picks
	// ---------------------------------------------------------------
	// Mostly short idle runs, a few long ones; none at all while calm.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Favor a small register window so results feed later instructions back to back.
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 9) < 7) return 5'($urandom_range(0, 7));
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [11:0] pick_imm12();
		case ($urandom_range(0, 9))
			0:       return 12'h7FF;
			1:       return 12'h800;
			2:       return 12'hFFF;
			3:       return 12'h000;
			default: return 12'($urandom);
		endcase
	endfunction

	// Loads, stores, reserved encodings and unknown opcodes.
	function automatic logic [31:0] rand_illegal(logic [4:0] rs1, logic [4:0] rs2, logic [4:0] rd,
			logic [2:0] f3);
		logic [6:0]  f7;
		logic [31:0] w;
		f7 = 7'($urandom_range(1, 127));
		case ($urandom_range(0, 7))
			0: return enc_i(pick_imm12(), rs1, f3, rd, OPC_LOAD);
			1: return enc_r(7'($urandom), rs2, rs1, f3, rd, OPC_STORE);
			2: return enc_i(pick_imm12(), rs1, 3'($urandom_range(1, 7)), rd, OP_JALR);
			3: return enc_b(13'($urandom), rs2, rs1, $urandom_range(0, 1) ? BR_RSV0 : BR_RSV1);
			4: return enc_i({f7, rs2}, rs1, F3_SLL, rd, OP_ALUI);
			5: begin
				if (f7 == F7_ALT) f7 = F7_ALT | 7'h01;
				return enc_i({f7, rs2}, rs1, F3_SR, rd, OP_ALUI);
			end
			6: begin
				// the alternate funct7 is legal only for ADD/SUB and SRL/SRA
				if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) f3 = F3_OR;
				return enc_r(f7, rs2, rs1, f3, rd, OP_ALUR);
			end
			default: begin
				w = $urandom;
				while (w[6:0] inside {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_ALUI, OP_ALUR})
					w = $urandom;
				return w;
			end
		endcase
	endfunction

	// Mostly well-formed instructions with random operands, some illegal ones, some raw noise.
	function automatic logic [31:0] rand_instr();
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [2:0] f3;
		int         pick;
		rd   = pick_reg();
		rs1  = pick_reg();
		rs2  = pick_reg();
		f3   = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			if (f3 == F3_SLL) return enc_i({F7_ZERO, rs2}, rs1, f3, rd, OP_ALUI);
			if (f3 == F3_SR)
				return enc_i({$urandom_range(0, 1) ? F7_ALT : F7_ZERO, rs2}, rs1, f3, rd, OP_ALUI);
			return enc_i(pick_imm12(), rs1, f3, rd, OP_ALUI);
		end
		if (pick < 40) begin
			if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1) == 1)
				return enc_r(F7_ALT, rs2, rs1, f3, rd, OP_ALUR);
			return enc_r(F7_ZERO, rs2, rs1, f3, rd, OP_ALUR);
		end
		if (pick < 48) return enc_u(20'($urandom), rd, OP_LUI);
		if (pick < 53) return enc_u(20'($urandom), rd, OP_AUIPC);
		if (pick < 60) return enc_j(21'($urandom), rd);
		if (pick < 66) return enc_i(pick_imm12(), rs1, JALR_F3, rd, OP_JALR);
		if (pick < 82) begin
			if (f3 == BR_RSV0 || f3 == BR_RSV1) f3 = BR_EQ;
			// same source twice makes EQ/GE/GEU taken and NE/LT/LTU not taken
			if ($urandom_range(0, 3) == 0) rs2 = rs1;
			return enc_b(13'($urandom), rs2, rs1, f3);
		end
		if (pick < 94) return rand_illegal(rs1, rs2, rd, f3);
		return $urandom;
	endfunction

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------
	// Holds valid and the word until the core takes the transaction.
	// With no gap, valid stays high straight into the next word.
	task automatic send_instr(logic [31:0] word, int gap);
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_valid <= 1'b1;
		instr_word  <= word;
		@(posedge clk);
		while (!instr_ready) @(posedge clk);
	endtask

	// Stop feeding until every outstanding retire record has come back.
	task automatic drain();
		instr_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Corner words: operand extremes, every operation, x0 writes, jump and
	// branch offset limits, odd JALR target, and each kind of no-op retire.
	task automatic run_directed();
		logic [31:0] prog [$];
		prog.push_back(enc_u(20'h80000, 5'd2, OP_LUI));
		prog.push_back(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd3, OP_ALUI));
		prog.push_back(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd4, OP_ALUI));
		prog.push_back(enc_i(12'h800, 5'd0, F3_OR, 5'd5, OP_ALUI));
		prog.push_back(enc_i(12'h800, 5'd3, F3_AND, 5'd6, OP_ALUI));
		prog.push_back(enc_i({F7_ALT, 5'd31}, 5'd2, F3_SR, 5'd7, OP_ALUI));
		prog.push_back(enc_i({F7_ZERO, 5'd31}, 5'd3, F3_SLL, 5'd8, OP_ALUI));
		prog.push_back(enc_r(F7_ZERO, 5'd2, 5'd2, F3_ADD, 5'd9, OP_ALUR));
		prog.push_back(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd10, OP_ALUR));
		prog.push_back(enc_r(F7_ZERO, 5'd4, 5'd3, F3_SLL, 5'd11, OP_ALUR));
		prog.push_back(enc_r(F7_ZERO, 5'd4, 5'd2, F3_SLT, 5'd12, OP_ALUR));
		prog.push_back(enc_r(F7_ZERO, 5'd4, 5'd2, F3_SLTU, 5'd13, OP_ALUR));
		prog.push_back(enc_r(F7_ZERO, 5'd2, 5'd3, F3_XOR, 5'd14, OP_ALUR));
		prog.push_back(enc_r(F7_ZERO, 5'd4, 5'd2, F3_SR, 5'd15, OP_ALUR));
		prog.push_back(enc_r(F7_ALT, 5'd4, 5'd2, F3_SR, 5'd16, OP_ALUR));
		prog.push_back(enc_r(F7_ZERO, 5'd4, 5'd2, F3_OR, 5'd17, OP_ALUR));
		prog.push_back(enc_r(F7_ZERO, 5'd6, 5'd3, F3_AND, 5'd18, OP_ALUR));
		prog.push_back(enc_i(12'd5, 5'd3, F3_ADD, 5'd0, OP_ALUI));
		prog.push_back(enc_u(20'hFFFFF, 5'd19, OP_AUIPC));
		prog.push_back(enc_j(21'h100000, 5'd20));
		prog.push_back(enc_i(12'h000, 5'd4, JALR_F3, 5'd21, OP_JALR));
		prog.push_back(enc_b(13'h0FFE, 5'd0, 5'd0, BR_EQ));
		prog.push_back(enc_b(13'h1000, 5'd3, 5'd3, BR_NE));
		prog.push_back(enc_b(13'h1000, 5'd4, 5'd2, BR_LT));
		prog.push_back(enc_b(13'h0008, 5'd4, 5'd2, BR_GE));
		prog.push_back(enc_b(13'h0010, 5'd2, 5'd4, BR_LTU));
		prog.push_back(enc_b(13'h0004, 5'd4, 5'd2, BR_GEU));
		prog.push_back(enc_i(12'h123, 5'd1, 3'd2, 5'd22, OPC_LOAD));
		prog.push_back(enc_r(7'h01, 5'd3, 5'd2, 3'd2, 5'd4, OPC_STORE));
		prog.push_back(enc_i(12'h000, 5'd1, 3'd1, 5'd23, OP_JALR));
		prog.push_back(enc_b(13'h0008, 5'd1, 5'd1, BR_RSV1));
		prog.push_back(enc_i({7'h01, 5'd3}, 5'd3, F3_SLL, 5'd24, OP_ALUI));
		prog.push_back(enc_i({7'h40, 5'd3}, 5'd3, F3_SR, 5'd25, OP_ALUI));
		prog.push_back(enc_r(F7_ALT, 5'd4, 5'd3, F3_XOR, 5'd26, OP_ALUR));
		prog.push_back(32'h0000_0000);
		prog.push_back(32'hFFFF_FFFF);
		foreach (prog[k]) send_instr(prog[k], pick_gap(1'b0));
	endtask

	// ---------------------------------------------------------------
	// Result sink: random back-pressure with occasional stall-free stretches
	// ---------------------------------------------------------------
	initial begin : result_sink
		bit calm;
		int stall;
		calm = 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) calm = ~calm;
			stall = pick_gap(calm);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		for (int i = 0; i < 420; i++) begin
			// every so often the sender runs flat out for a while
			if (i % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
			if (i == 210) drain();
			send_instr(rand_instr(), pick_gap(send_calm));
		end
		instr_valid <= 1'b0;

		// wait out the outstanding retire records, then a few cycles for strays
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rvxc_pkg.sv
hw/rtl/rvxc_front.sv
hw/rtl/rvxc_fifo.sv
hw/rtl/rvxc_back.sv
hw/rtl/rv32i_integer_execute_core_unit.sv
hw/rtl/rvxc_checker.sv
tb/tb_top.sv
